>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// commands, status codes, field widths and the sequencer state type
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
	localparam int WIDTH = 32;
	localparam int MW    = 2 * WIDTH;   // intermediate magnitude width

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_NEG  = 3'd4,
		CMD_NORM = 3'd5,
		CMD_EQ   = 3'd6,
		CMD_RSVD = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [WIDTH-1:0]  num_a;
		logic [WIDTH-1:0]  den_a;
		logic [WIDTH-1:0]  num_b;
		logic [WIDTH-1:0]  den_b;
	} in_req_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic        is_equal;
		logic [1:0]  status;
	} out_req_t;

	// reduction request/response between sequencer and reducer
	typedef struct packed {
		logic          start;
		logic [MW-1:0] n;
		logic [MW-1:0] d;
	} red_req_t;

	typedef struct packed {
		logic          done;
		logic [MW-1:0] n;
		logic [MW-1:0] d;
	} red_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RED_A, S_WAIT_A, S_RED_B, S_WAIT_B, S_MUL1, S_MUL2,
		S_MUL3, S_RED_R, S_WAIT_R, S_OUT
	} seq_state_t;

	typedef enum logic [2:0] {
		R_IDLE, R_GCD, R_DIVN, R_DIVD, R_DONE
	} red_state_t;
endpackage
`default_nettype wire

>>> design/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if: valid/ready channel carrying one request payload
// generic over the payload type
// ----------------------------------------------------------------------------
`default_nettype none
interface rau_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/rau_reduce.sv
// ----------------------------------------------------------------------------
// rau_reduce: lowest-terms reduction of a magnitude pair
// euclid gcd with a shared restoring divider, then n/g and d/g
// ----------------------------------------------------------------------------
`default_nettype none
module rau_reduce (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rau_pkg::red_req_t req,
	output rau_pkg::red_rsp_t  rsp
);
	import rau_pkg::*;

	localparam int CW = $clog2(MW + 1);

	red_state_t    state_q, state_d;
	logic [MW-1:0] n_q, d_q, x_q, y_q;
	logic [MW-1:0] quo_q, rem_q, dvd_q;
	logic [CW-1:0] cnt_q;
	logic          div_busy_q;
	logic [MW:0]   trial;
	logic [MW-1:0] rem_sh;
	logic [MW-1:0] divisor;

	// divisor chosen by phase
	always_comb begin
		unique case (state_q)
			R_GCD:   divisor = y_q;
			default: divisor = x_q;
		endcase
	end

	// one restoring division step
	assign rem_sh = {rem_q[MW-2:0], dvd_q[MW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, divisor};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			R_IDLE: if (req.start) state_d = R_GCD;
			R_GCD:  if (!div_busy_q && y_q == '0) state_d = R_DIVN;
			R_DIVN: if (div_busy_q && cnt_q == CW'(0)) state_d = R_DIVD;
			R_DIVD: if (div_busy_q && cnt_q == CW'(0)) state_d = R_DONE;
			R_DONE: state_d = R_IDLE;
			default: state_d = R_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= R_IDLE;
			div_busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				R_IDLE: div_busy_q <= 1'b0;
				R_GCD: begin
					if (!div_busy_q) div_busy_q <= (y_q != '0);
					else if (cnt_q == CW'(0)) div_busy_q <= 1'b0;
				end
				R_DIVN, R_DIVD: begin
					if (!div_busy_q) div_busy_q <= 1'b1;
					else if (cnt_q == CW'(0)) div_busy_q <= (state_q == R_DIVN);
				end
				default: div_busy_q <= 1'b0;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				n_q <= req.n;
				d_q <= req.d;
				x_q <= req.n;
				y_q <= req.d;
			end
			R_GCD: begin
				if (!div_busy_q) begin
					dvd_q <= x_q;
					rem_q <= '0;
					cnt_q <= CW'(MW - 1);
				end else begin
					dvd_q <= {dvd_q[MW-2:0], 1'b0};
					rem_q <= trial[MW] ? rem_sh : trial[MW-1:0];
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(0)) begin
						x_q <= y_q;
						y_q <= trial[MW] ? rem_sh : trial[MW-1:0];
					end
				end
			end
			R_DIVN, R_DIVD: begin
				if (!div_busy_q) begin
					dvd_q <= (state_q == R_DIVN) ? n_q : d_q;
					rem_q <= '0;
					cnt_q <= CW'(MW - 1);
				end else if (cnt_q == CW'(0)) begin
					// last step: store the quotient, start on d after n
					if (state_q == R_DIVN) begin
						n_q   <= {quo_q[MW-2:0], ~trial[MW]};
						dvd_q <= d_q;
						rem_q <= '0;
						cnt_q <= CW'(MW - 1);
					end else begin
						d_q <= {quo_q[MW-2:0], ~trial[MW]};
					end
				end else begin
					dvd_q <= {dvd_q[MW-2:0], 1'b0};
					rem_q <= trial[MW] ? rem_sh : trial[MW-1:0];
					quo_q <= {quo_q[MW-2:0], ~trial[MW]};
					cnt_q <= cnt_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign rsp = {(state_q == R_DONE), n_q, d_q};

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("reduce done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == R_DONE |=> state_q == R_IDLE) else $error("reduce not idle");
	a_gcd_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_GCD && state_d == R_DIVN) |-> x_q != '0 || n_q == '0)
		else $error("zero gcd");
endmodule
`default_nettype wire

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact rational add/sub/mul/div/negate/normalize/eq
// operands reduced, cross products formed, result reduced by gcd
// ----------------------------------------------------------------------------
// Usage: one request on in_ch carries cmd and two fractions; one response
// leaves on out_ch with the lowest-terms result and a status. in_ch.ready is
// high only while the sequencer is idle. Every request runs two operand
// reductions, and add, sub, mul and div a third on the result unless a
// denominator or divisor is zero, all on one shared restoring divider.
// Each euclid round is a setup step and 64 remainder steps; an operand
// needs up to about 46 rounds, a result up to about 92. Mul and div use
// the single 32x32 multiplier in states S_MUL1 and S_MUL2, add and sub
// also in S_MUL3. Latency is set by the divider loop in rau_reduce.
// The response is held in an output register while out_ch.ready is low; the
// next request may be taken and worked on meanwhile, and its sequencer waits
// in the output state until the register is free. Reset (arst_n low) returns
// the sequencer to idle and drops out_ch.valid.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit (
	input wire logic clk,
	input wire logic arst_n,
	rau_if.sink      in_ch,
	rau_if.source    out_ch
);
	import rau_pkg::*;

	localparam logic [MW-1:0] LIM = MW'(1) << (WIDTH - 1);

	seq_state_t    state_q, state_d;
	in_req_t       req_q;
	logic          an_q, bn_q, rn_q;
	logic [MW-1:0] an_mag_q, ad_q, bn_mag_q, bd_q;
	logic [MW-1:0] p_q, rn_mag_q, rd_q;
	logic          azero_q, bzero_q;
	red_req_t      red_req;
	red_rsp_t      red_rsp;
	out_req_t      out_q;
	out_req_t      out_d;
	logic          out_valid_q;
	logic [WIDTH-1:0] m_a, m_b;
	logic [MW-1:0] prod;
	logic          nna, dna, nnb, dnb;
	logic [WIDTH-1:0] mna, mda, mnb, mdb;
	logic          sub_b;
	logic [MW-1:0] sum;
	logic          sum_neg;
	logic [MW-1:0] neg_num;

	// magnitude of a signed field
	function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
		mag = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
	endfunction

	assign nna = req_q.num_a[WIDTH-1];
	assign dna = req_q.den_a[WIDTH-1];
	assign nnb = req_q.num_b[WIDTH-1];
	assign dnb = req_q.den_b[WIDTH-1];
	assign mna = mag(req_q.num_a);
	assign mda = mag(req_q.den_a);
	assign mnb = mag(req_q.num_b);
	assign mdb = mag(req_q.den_b);

	// shared multiplier, operands chosen per step
	always_comb begin
		m_a = '0;
		m_b = '0;
		unique case (state_q)
			S_MUL1: begin
				m_a = an_mag_q[WIDTH-1:0];
				m_b = (req_q.cmd == CMD_MUL) ? bn_mag_q[WIDTH-1:0] : bd_q[WIDTH-1:0];
			end
			S_MUL2: begin
				m_a = (req_q.cmd == CMD_MUL || req_q.cmd == CMD_DIV)
					? ad_q[WIDTH-1:0] : bn_mag_q[WIDTH-1:0];
				m_b = (req_q.cmd == CMD_MUL) ? bd_q[WIDTH-1:0]
					: (req_q.cmd == CMD_DIV) ? bn_mag_q[WIDTH-1:0] : ad_q[WIDTH-1:0];
			end
			S_MUL3: begin
				m_a = ad_q[WIDTH-1:0];
				m_b = bd_q[WIDTH-1:0];
			end
			default: ;
		endcase
	end
	assign prod = MW'(m_a) * MW'(m_b);

	// signed sum of the cross products
	assign sub_b = bn_q ^ (req_q.cmd == CMD_SUB);
	always_comb begin
		if (an_q == sub_b) begin
			sum = p_q + prod;
			sum_neg = an_q;
		end else if (p_q >= prod) begin
			sum = p_q - prod;
			sum_neg = an_q;
		end else begin
			sum = prod - p_q;
			sum_neg = sub_b;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_ch.valid) state_d = S_RED_A;
			S_RED_A:  state_d = S_WAIT_A;
			S_WAIT_A: if (red_rsp.done) state_d = S_RED_B;
			S_RED_B:  state_d = S_WAIT_B;
			S_WAIT_B: begin
				if (red_rsp.done) begin
					if (req_q.cmd == CMD_RSVD || azero_q || req_q.cmd == CMD_EQ
						|| req_q.cmd == CMD_NEG || req_q.cmd == CMD_NORM)
						state_d = S_OUT;
					else if (bzero_q || (req_q.cmd == CMD_DIV && red_rsp.n == '0))
						state_d = S_OUT;
					else
						state_d = S_MUL1;
				end
			end
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = (req_q.cmd == CMD_ADD || req_q.cmd == CMD_SUB)
				? S_MUL3 : S_RED_R;
			S_MUL3:   state_d = S_RED_R;
			S_RED_R:  state_d = S_WAIT_R;
			S_WAIT_R: if (red_rsp.done) state_d = S_OUT;
			S_OUT:    if (!out_valid_q) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// reducer requests
	always_comb begin
		red_req.start = 1'b0;
		red_req.n = '0;
		red_req.d = '0;
		unique case (state_q)
			S_RED_A: begin
				red_req.start = 1'b1;
				red_req.n = MW'(mna);
				red_req.d = MW'(mda);
			end
			S_RED_B: begin
				red_req.start = 1'b1;
				red_req.n = MW'(mnb);
				red_req.d = MW'(mdb);
			end
			S_RED_R: begin
				red_req.start = 1'b1;
				red_req.n = rn_mag_q;
				red_req.d = rd_q;
			end
			default: ;
		endcase
	end

	rau_reduce u_red (.clk(clk), .arst_n(arst_n), .req(red_req), .rsp(red_rsp));

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_ch.valid) req_q <= in_ch.data;
			S_RED_A: begin
				azero_q <= (mda == '0);
				an_q <= nna ^ dna;
			end
			S_WAIT_A: if (red_rsp.done) begin
				an_mag_q <= red_rsp.n;
				ad_q <= (red_rsp.n == '0) ? MW'(1) : red_rsp.d;
				if (red_rsp.n == '0) an_q <= 1'b0;
			end
			S_RED_B: begin
				bzero_q <= (mdb == '0);
				bn_q <= nnb ^ dnb;
			end
			S_WAIT_B: if (red_rsp.done) begin
				bn_mag_q <= red_rsp.n;
				bd_q <= (red_rsp.n == '0) ? MW'(1) : red_rsp.d;
				if (red_rsp.n == '0) bn_q <= 1'b0;
				rn_q <= (req_q.cmd == CMD_NEG) ? ~an_q : an_q;
				rn_mag_q <= an_mag_q;
				rd_q <= ad_q;
			end
			S_MUL1: begin
				p_q <= prod;
				rn_q <= an_q ^ bn_q;
			end
			S_MUL2: begin
				if (req_q.cmd == CMD_ADD || req_q.cmd == CMD_SUB) begin
					rn_mag_q <= sum;
					rn_q <= sum_neg;
				end else begin
					rn_mag_q <= p_q;
					rd_q <= prod;
				end
			end
			S_MUL3: rd_q <= prod;
			S_WAIT_R: if (red_rsp.done) begin
				rn_mag_q <= red_rsp.n;
				rd_q <= (red_rsp.n == '0) ? MW'(1) : red_rsp.d;
				if (red_rsp.n == '0) rn_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// result formatting
	assign neg_num = rn_q ? (~rn_mag_q + MW'(1)) : rn_mag_q;

	always_comb begin
		out_d = '0;
		if (req_q.cmd == CMD_RSVD) begin
			out_d.status = ST_OK;
		end else if (azero_q || (req_q.cmd != CMD_NEG && req_q.cmd != CMD_NORM
			&& (bzero_q || (req_q.cmd == CMD_DIV && bn_mag_q == '0)))) begin
			out_d.status = ST_ZDEN;
		end else if (req_q.cmd == CMD_EQ) begin
			out_d.is_equal = (an_q == bn_q) && (an_mag_q == bn_mag_q)
				&& (ad_q == bd_q);
		end else if (rd_q > LIM - MW'(1) || rn_mag_q > (rn_q ? LIM : LIM - MW'(1))) begin
			out_d.status = ST_OVF;
		end else begin
			out_d.res_num = neg_num[31:0];
			out_d.res_den = rd_q[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_valid_q) begin
			if (out_ch.ready) out_valid_q <= 1'b0;
		end else if (state_q == S_OUT) begin
			out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && !out_valid_q) out_q <= out_d;
	end

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("response changed while stalled");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("stray response");
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.res_num == '0 && out_q.res_den == '0)
		else $error("error with payload");
endmodule
`default_nettype wire

>>> verif/tb_rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench of the rational unit
// directed table then random fractions, checked against a behavioral predictor
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rational_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] na, da, nb, db;
		logic        has_exp;
		logic [31:0] e_num;
		logic [30:0] e_den;
		logic        e_eq;
		logic [1:0]  e_st;
	} dir_row_t;

	typedef struct {
		logic        neg;
		logic [63:0] n;
		logic [63:0] d;
	} frac_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rau_if #(.payload_t(in_req_t))  in_ch ();
	rau_if #(.payload_t(out_req_t)) out_ch ();

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	out_req_t   expected_q[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	logic       calm = 1'b0;
	logic       in_done = 1'b0;
	in_req_t    req_q[$];

	// euclid gcd on magnitudes
	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_t lowest_terms(frac_t f);
		logic [63:0] g;
		g = gcd64(f.n, f.d);
		if (g != 0) begin
			f.n = f.n / g;
			f.d = f.d / g;
		end
		if (f.n == 0) begin
			f.neg = 1'b0;
			f.d = 64'd1;
		end
		return f;
	endfunction

	function automatic frac_t to_frac(logic [31:0] nf, logic [31:0] df);
		frac_t f;
		f.neg = nf[31] ^ df[31];
		f.n = nf[31] ? 64'(-$signed({32'hffffffff, nf})) : {32'd0, nf};
		f.d = df[31] ? 64'(-$signed({32'hffffffff, df})) : {32'd0, df};
		if (f.d == 0)
			return f;
		return lowest_terms(f);
	endfunction

	function automatic out_req_t predict_rational(in_req_t q);
		out_req_t o;
		frac_t a, b, r;
		logic [63:0] lim, x, y, nb;
		logic bneg, uses_b;
		a = to_frac(q.num_a, q.den_a);
		b = to_frac(q.num_b, q.den_b);
		lim = 64'd1 << (WIDTH - 1);
		uses_b = (q.cmd <= CMD_DIV) || (q.cmd == CMD_EQ);
		o = '0;
		if (q.cmd == CMD_RSVD)
			return o;
		if (a.d == 0 || (uses_b && b.d == 0) || (q.cmd == CMD_DIV && b.n == 0)) begin
			o.status = ST_ZDEN;
			return o;
		end
		if (q.cmd == CMD_EQ) begin
			o.is_equal = (a.neg == b.neg && a.n == b.n && a.d == b.d);
			return o;
		end
		r = a;
		case (q.cmd)
			CMD_ADD, CMD_SUB: begin
				x = a.n * b.d;
				y = b.n * a.d;
				bneg = b.neg ^ (q.cmd == CMD_SUB);
				if (a.neg == bneg) begin
					r.neg = a.neg;
					r.n = x + y;
				end else if (x >= y) begin
					r.neg = a.neg;
					r.n = x - y;
				end else begin
					r.neg = bneg;
					r.n = y - x;
				end
				r.d = a.d * b.d;
			end
			CMD_MUL: begin
				r.neg = a.neg ^ b.neg;
				r.n = a.n * b.n;
				r.d = a.d * b.d;
			end
			CMD_DIV: begin
				r.neg = a.neg ^ b.neg;
				r.n = a.n * b.d;
				r.d = a.d * b.n;
			end
			CMD_NEG: r.neg = !a.neg;
			default: ;
		endcase
		r = lowest_terms(r);
		if (r.d > lim - 1 || r.n > (r.neg ? lim : lim - 1)) begin
			o.status = ST_OVF;
			return o;
		end
		nb = r.neg ? -r.n : r.n;
		o.res_num = nb[31:0];
		o.res_den = r.d[30:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	// directed table
	dir_row_t dir_rows[$];
	task automatic add_row(logic [2:0] c, logic [31:0] na, logic [31:0] da,
			logic [31:0] nb, logic [31:0] db, logic he = 0, logic [31:0] en = 0,
			logic [30:0] ed = 0, logic ee = 0, logic [1:0] es = ST_OK);
		dir_row_t r;
		r = '{c, na, da, nb, db, he, en, ed, ee, es};
		dir_rows.push_back(r);
	endtask

	initial begin
		add_row(CMD_ADD, 1, 2, 1, 3);
		add_row(CMD_SUB, 1, 2, 1, 2, 1, 0, 1, 0, ST_OK);
		add_row(CMD_MUL, -2, 4, 3, -9);
		add_row(CMD_DIV, 5, 7, 0, 3, 1, 0, 0, 0, ST_ZDEN);
		add_row(CMD_ADD, 1, 0, 1, 1, 1, 0, 0, 0, ST_ZDEN);
		add_row(CMD_MUL, 1, 1, 1, 0, 1, 0, 0, 0, ST_ZDEN);
		add_row(CMD_NEG, 3, 0, 1, 0, 1, 0, 0, 0, ST_ZDEN);
		add_row(CMD_NEG, 32'h80000000, 1, 7, 0, 1, 0, 0, 0, ST_OVF);
		add_row(CMD_NORM, 32'h80000000, 1, 0, 0, 1, 32'h80000000, 1, 0, ST_OK);
		add_row(CMD_NORM, 1, 32'h80000000, 5, 5, 1, 0, 0, 0, ST_OVF);
		add_row(CMD_NORM, 6, -4, 0, 0, 1, -3, 2, 0, ST_OK);
		add_row(CMD_NORM, 0, -5, 0, 0, 1, 0, 1, 0, ST_OK);
		add_row(CMD_EQ, 2, 4, -1, -2, 1, 0, 0, 1, ST_OK);
		add_row(CMD_EQ, 2, 4, 1, 3, 1, 0, 0, 0, ST_OK);
		add_row(CMD_EQ, 2, 0, 1, 3, 1, 0, 0, 0, ST_ZDEN);
		add_row(CMD_RSVD, 1, 1, 1, 1, 1, 0, 0, 0, ST_OK);
		add_row(CMD_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1);
		add_row(CMD_SUB, 32'h80000000, 1, 1, 1);
		add_row(CMD_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		add_row(CMD_DIV, 32'hffffffff, 32'hffffffff, 32'h80000000, 32'h7ffffffe);
		add_row(CMD_ADD, 1, 32'h7fffffff, 1, 32'h7ffffffe);
		add_row(CMD_MUL, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		add_row(CMD_DIV, 0, 5, 3, 4);
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'($signed($urandom_range(0, 40)) - 20);
			3, 4, 5: return $urandom_range(0, 2000) - 1000;
			6: return 32'($urandom_range(0, 65535)) * (($urandom & 1) ? 1 : -1);
			default: return $urandom;
		endcase
	endfunction

	// request driver, falling edge
	initial begin
		in_req_t q;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		foreach (dir_rows[i]) begin
			q.cmd = dir_rows[i].cmd;
			q.num_a = dir_rows[i].na;
			q.den_a = dir_rows[i].da;
			q.num_b = dir_rows[i].nb;
			q.den_b = dir_rows[i].db;
			req_q.push_back(q);
		end
		for (int i = 0; i < 600; i++) begin
			q.cmd = 3'($urandom_range(0, 7));
			q.num_a = rand_field();
			q.den_a = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_field();
			q.num_b = rand_field();
			q.den_b = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_field();
			req_q.push_back(q);
		end
		while (req_q.size() > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			if (calm || $urandom_range(0, 99) >= 31) begin
				in_ch.data = req_q.pop_front();
				in_ch.valid = 1'b1;
				// hold the request until the edge that accepts it
				@(posedge clk);
				while (!in_ch.ready) @(posedge clk);
			end
		end
		@(negedge clk);
		in_ch.valid = 1'b0;
		in_done = 1'b1;
	end

	// stretch without random gaps or stalls
	initial begin
		#40000 calm = 1'b1;
		#40000 calm = 1'b0;
	end

	// response ready, random stalls
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
	end

	// scoreboard and watchdog at the rising edge
	always @(posedge clk) begin
		out_req_t got, want;
		if (in_ch.valid && in_ch.ready) begin
			want = predict_rational(in_ch.data);
			expected_q.push_back(want);
		end
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected response", 64'(got.res_num), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (got.res_num !== want.res_num)
					report_mismatch("res_num", 64'(got.res_num), 64'(want.res_num));
				if (got.res_den !== want.res_den)
					report_mismatch("res_den", 64'(got.res_den), 64'(want.res_den));
				if (got.is_equal !== want.is_equal)
					report_mismatch("is_equal", 64'(got.is_equal), 64'(want.is_equal));
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// typed-in expectations of the directed table
	initial begin
		out_req_t got;
		int i;
		i = 0;
		@(posedge arst_n);
		while (i < dir_rows.size()) begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (dir_rows[i].has_exp && (got.res_num !== dir_rows[i].e_num ||
						got.res_den !== dir_rows[i].e_den ||
						got.is_equal !== dir_rows[i].e_eq ||
						got.status !== dir_rows[i].e_st))
					report_mismatch($sformatf("directed row %0d", i),
						{got.status, got.is_equal, got.res_den, got.res_num[29:0]},
						{dir_rows[i].e_st, dir_rows[i].e_eq, dir_rows[i].e_den,
							dir_rows[i].e_num[29:0]});
				i++;
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		while (!(in_done && expected_q.size() == 0)) begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_rational_arithmetic_unit: FAIL");
				$finish;
			end
		end
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_rational_arithmetic_unit: PASS");
		else
			$display("tb_rational_arithmetic_unit: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
